>>> rtl/core/wesc_pkg.sv
// Shared types, constants and helpers of the windowed event score correlator.
package wesc_pkg;

   localparam int TIME_W     = 48;
   localparam int CAT_W      = 3;
   localparam int WIN_W      = 24;
   localparam int THR_W      = 10;
   localparam int WGT_W      = 4;
   localparam int CNT_W      = 7;
   localparam int SCORE_W    = 10;
   localparam int NUM_CAT    = 4;
   localparam int KEY_W      = NUM_CAT * CNT_W;
   localparam int ACC_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CNT_W-1:0]   CNT_MAX   = 7'd127;
   localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRUNE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT0   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT1   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT2   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT3   = 3'd6;

   localparam logic [WIN_W-1:0] WINDOW_RST    = 24'd60000;
   localparam logic [WIN_W-1:0] PRUNE_RST     = 24'd5000;
   localparam logic [THR_W-1:0] THRESHOLD_RST = 10'd5;
   localparam logic [WGT_W-1:0] WEIGHT0_RST   = 4'd1;
   localparam logic [WGT_W-1:0] WEIGHT1_RST   = 4'd2;
   localparam logic [WGT_W-1:0] WEIGHT2_RST   = 4'd3;
   localparam logic [WGT_W-1:0] WEIGHT3_RST   = 4'd4;

   typedef logic [NUM_CAT-1:0][CNT_W-1:0] count_vec_type;
   typedef logic [NUM_CAT-1:0][WGT_W-1:0] weight_vec_type;

   typedef struct packed {
      logic [CAT_W-1:0]  cat;
      logic [TIME_W-1:0] t;
   } event_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      sat_inc = (value == CNT_MAX) ? value : value + CNT_W'(1);
   endfunction

endpackage

>>> rtl/core/wesc_mac.sv
// Iterative multiply-accumulate that forms the saturated weighted score.
module wesc_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  wesc_pkg::count_vec_type            counts,
   input  wesc_pkg::weight_vec_type           weights,
   output logic                               done,
   output logic [wesc_pkg::SCORE_W-1:0]       score
);
   import wesc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        step_ff, step_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [WGT_W+CNT_W-1:0] product;

   assign product = weights[step_ff] * counts[step_ff];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + ACC_W'(product);
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      acc_ff <= acc_in;
   end

   assign done  = done_ff;
   assign score = (acc_ff > ACC_W'(SCORE_MAX)) ? SCORE_MAX : acc_ff[SCORE_W-1:0];

endmodule

>>> rtl/core/windowed_event_score_correlator_core.sv
// Top level of the windowed event score correlator.
// Flow: a request is accepted in idle, the stored events are scanned, the new event is
// appended and the MAC forms the score; only when the score meets the threshold are the
// recorded tuples scanned and an unseen tuple added, then the result is registered. A new
// request is taken only after the last result loads, which waits while a result waits on rsp_stall.
// Reset: registers return to defaults, counts and last prune time clear; the stores are
// not cleared, only entries below their fill counts are read.
module windowed_event_score_correlator_core #(
   parameter int EVENT_DEPTH = 64,
   parameter int TUPLE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [wesc_pkg::CAT_W-1:0]           req_category,
   input  logic [wesc_pkg::TIME_W-1:0]          req_now_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_report,
   output logic [wesc_pkg::SCORE_W-1:0]         rsp_score,
   output logic [wesc_pkg::CNT_W-1:0]           rsp_count_cat0,
   output logic [wesc_pkg::CNT_W-1:0]           rsp_count_cat1,
   output logic [wesc_pkg::CNT_W-1:0]           rsp_count_cat2,
   output logic [wesc_pkg::CNT_W-1:0]           rsp_count_cat3,
   output logic                                 rsp_store_full,
   output logic                                 rsp_tuple_table_full,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wesc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wesc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import wesc_pkg::*;

   localparam int EIW = $clog2(EVENT_DEPTH);
   localparam int ECW = $clog2(EVENT_DEPTH + 1);
   localparam int TIW = $clog2(TUPLE_DEPTH);
   localparam int TCW = $clog2(TUPLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_APPEND  = 3'd2;
   localparam logic [2:0] ST_SCORE   = 3'd3;
   localparam logic [2:0] ST_TSCAN   = 3'd4;
   localparam logic [2:0] ST_TDECIDE = 3'd5;
   localparam logic [2:0] ST_OUT     = 3'd6;

   event_type         ev_mem [EVENT_DEPTH];
   logic [KEY_W-1:0]  tt_mem [TUPLE_DEPTH];

   logic [WIN_W-1:0]  window_ff;
   logic [WIN_W-1:0]  prune_ff;
   logic [THR_W-1:0]  thresh_ff;
   weight_vec_type    weight_ff;

   logic [2:0]        state_ff, state_in;
   logic [CAT_W-1:0]  cat_ff, cat_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] last_prune_ff, last_prune_in;
   logic              compact_ff, compact_in;
   logic [ECW-1:0]    ev_count_ff, ev_count_in;
   logic [ECW-1:0]    idx_ff, idx_in;
   logic [ECW-1:0]    wr_ff, wr_in;
   logic [TCW-1:0]    tt_count_ff, tt_count_in;
   logic [TCW-1:0]    tidx_ff, tidx_in;
   logic              vld_ff, vld_in;
   count_vec_type     cnt_ff, cnt_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic              seen_ff, seen_in;
   logic              full_ff, full_in;
   logic              rep_ff, rep_in;
   logic              tfull_ff, tfull_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_report_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   count_vec_type     rsp_cnt_ff;
   logic              rsp_full_ff;
   logic              rsp_tfull_ff;
   logic              rsp_load;

   event_type         ev_rdata_ff;
   logic [EIW-1:0]    ev_raddr;
   logic              ev_we;
   logic [EIW-1:0]    ev_waddr;
   event_type         ev_wdata;
   logic [KEY_W-1:0]  tt_rdata_ff;
   logic [TIW-1:0]    tt_raddr;
   logic              tt_we;
   logic [TIW-1:0]    tt_waddr;

   logic              accept;
   logic              mac_start;
   logic              mac_done;
   logic [SCORE_W-1:0] mac_score;
   logic [KEY_W-1:0]  key;
   logic [ECW-1:0]    base;
   logic              in_window;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign key       = {cnt_ff[3], cnt_ff[2], cnt_ff[1], cnt_ff[0]};
   assign base      = compact_ff ? wr_ff : ev_count_ff;
   assign in_window = ((now_ff - ev_rdata_ff.t) <= TIME_W'(window_ff));

   wesc_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .counts  (cnt_ff),
      .weights (weight_ff),
      .done    (mac_done),
      .score   (mac_score)
   );

   always_comb begin
      state_in      = state_ff;
      cat_in        = cat_ff;
      now_in        = now_ff;
      last_prune_in = last_prune_ff;
      compact_in    = compact_ff;
      ev_count_in   = ev_count_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      tt_count_in   = tt_count_ff;
      tidx_in       = tidx_ff;
      vld_in        = 1'b0;
      cnt_in        = cnt_ff;
      score_in      = score_ff;
      seen_in       = seen_ff;
      full_in       = full_ff;
      rep_in        = rep_ff;
      tfull_in      = tfull_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      mac_start     = 1'b0;
      ev_raddr      = idx_ff[EIW-1:0];
      ev_we         = 1'b0;
      ev_waddr      = wr_ff[EIW-1:0];
      ev_wdata      = ev_rdata_ff;
      tt_raddr      = tidx_ff[TIW-1:0];
      tt_we         = 1'b0;
      tt_waddr      = tt_count_ff[TIW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cat_in  = req_category;
               now_in  = req_now_ms;
               compact_in = ((req_now_ms - last_prune_ff) >= TIME_W'(prune_ff));
               if (compact_in) begin
                  last_prune_in = req_now_ms;
               end
               idx_in   = '0;
               wr_in    = '0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff < ev_count_ff) begin
               idx_in = idx_ff + ECW'(1);
               vld_in = 1'b1;
            end
            if (vld_ff) begin
               if (in_window && !ev_rdata_ff.cat[2]) begin
                  cnt_in[ev_rdata_ff.cat[1:0]] = sat_inc(cnt_ff[ev_rdata_ff.cat[1:0]]);
               end
               if (compact_ff && in_window) begin
                  ev_we = 1'b1;
                  wr_in = wr_ff + ECW'(1);
               end
            end else if (idx_ff == ev_count_ff) begin
               state_in = ST_APPEND;
            end
         end
         ST_APPEND: begin
            ev_waddr       = base[EIW-1:0];
            ev_wdata.cat   = cat_ff;
            ev_wdata.t     = now_ff;
            if (base < ECW'(EVENT_DEPTH)) begin
               ev_we       = 1'b1;
               ev_count_in = base + ECW'(1);
               full_in     = 1'b0;
               if (!cat_ff[2]) begin
                  cnt_in[cat_ff[1:0]] = sat_inc(cnt_ff[cat_ff[1:0]]);
               end
            end else begin
               ev_count_in = base;
               full_in     = 1'b1;
            end
            mac_start = 1'b1;
            state_in  = ST_SCORE;
         end
         ST_SCORE: begin
            if (mac_done) begin
               score_in = mac_score;
               rep_in   = 1'b0;
               tfull_in = 1'b0;
               seen_in  = 1'b0;
               tidx_in  = '0;
               state_in = (mac_score >= thresh_ff) ? ST_TSCAN : ST_OUT;
            end
         end
         ST_TSCAN: begin
            if (tidx_ff < tt_count_ff) begin
               tidx_in = tidx_ff + TCW'(1);
               vld_in  = 1'b1;
            end
            if (vld_ff) begin
               if (tt_rdata_ff == key) begin
                  seen_in = 1'b1;
               end
            end else if (tidx_ff == tt_count_ff) begin
               state_in = ST_TDECIDE;
            end
         end
         ST_TDECIDE: begin
            if (!seen_ff) begin
               rep_in = 1'b1;
               if (tt_count_ff < TCW'(TUPLE_DEPTH)) begin
                  tt_we       = 1'b1;
                  tt_count_in = tt_count_ff + TCW'(1);
               end else begin
                  tfull_in = 1'b1;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_prune_ff <= '0;
         ev_count_ff   <= '0;
         tt_count_ff   <= '0;
         vld_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_prune_ff <= last_prune_in;
         ev_count_ff   <= ev_count_in;
         tt_count_ff   <= tt_count_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cat_ff     <= cat_in;
      now_ff     <= now_in;
      compact_ff <= compact_in;
      idx_ff     <= idx_in;
      wr_ff      <= wr_in;
      tidx_ff    <= tidx_in;
      cnt_ff     <= cnt_in;
      score_ff   <= score_in;
      seen_ff    <= seen_in;
      full_ff    <= full_in;
      rep_ff     <= rep_in;
      tfull_ff   <= tfull_in;
      if (rsp_load) begin
         rsp_report_ff <= rep_ff;
         rsp_score_ff  <= score_ff;
         rsp_cnt_ff    <= cnt_ff;
         rsp_full_ff   <= full_ff;
         rsp_tfull_ff  <= tfull_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RST;
         prune_ff  <= PRUNE_RST;
         thresh_ff <= THRESHOLD_RST;
         weight_ff <= {WEIGHT3_RST, WEIGHT2_RST, WEIGHT1_RST, WEIGHT0_RST};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW:    window_ff    <= csr_data;
            REG_PRUNE:     prune_ff     <= csr_data;
            REG_THRESHOLD: thresh_ff    <= csr_data[THR_W-1:0];
            REG_WEIGHT0:   weight_ff[0] <= csr_data[WGT_W-1:0];
            REG_WEIGHT1:   weight_ff[1] <= csr_data[WGT_W-1:0];
            REG_WEIGHT2:   weight_ff[2] <= csr_data[WGT_W-1:0];
            REG_WEIGHT3:   weight_ff[3] <= csr_data[WGT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         ev_mem[ev_waddr] <= ev_wdata;
      end
      ev_rdata_ff <= ev_mem[ev_raddr];
   end

   always_ff @(posedge clock) begin
      if (tt_we) begin
         tt_mem[tt_waddr] <= key;
      end
      tt_rdata_ff <= tt_mem[tt_raddr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_report           = rsp_report_ff;
   assign rsp_score            = rsp_score_ff;
   assign rsp_count_cat0       = rsp_cnt_ff[0];
   assign rsp_count_cat1       = rsp_cnt_ff[1];
   assign rsp_count_cat2       = rsp_cnt_ff[2];
   assign rsp_count_cat3       = rsp_cnt_ff[3];
   assign rsp_store_full       = rsp_full_ff;
   assign rsp_tuple_table_full = rsp_tfull_ff;

endmodule
